FILE: sv/clock_digit_row_renderer_assert.svh
// Assertion macros for the clock digit row renderer checker
`ifndef CLOCK_DIGIT_ROW_RENDERER_ASSERT_SVH
`define CLOCK_DIGIT_ROW_RENDERER_ASSERT_SVH

// Implication checked outside reset
`define CDR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property checked at every edge, reset included
`define CDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cdr_pkg.sv
// Types, constants, font tables and digit split for the clock digit row renderer
`default_nettype none

package cdr_pkg;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ROW  = 1'b1;

   localparam int unsigned SEC_WIDTH  = 6;
   localparam int unsigned MIN_WIDTH  = 6;
   localparam int unsigned HOUR_WIDTH = 5;

   localparam logic [SEC_WIDTH-1:0]  SEC_LAST  = 6'd59;
   localparam logic [MIN_WIDTH-1:0]  MIN_LAST  = 6'd59;
   localparam logic [HOUR_WIDTH-1:0] HOUR_LAST = 5'd23;

   localparam logic [3:0] LAST_GLYPH_ROW    = 4'd7;
   localparam logic [3:0] FIRST_SECONDS_ROW = 4'd3;

   localparam int unsigned HOUR_TENS_POS = 27;
   localparam int unsigned HOUR_UNIT_POS = 22;
   localparam int unsigned MIN_TENS_POS  = 13;
   localparam int unsigned MIN_UNIT_POS  = 8;
   localparam int unsigned SEC_TENS_POS  = 4;
   localparam int unsigned COLON_POS     = 19;

   typedef struct packed {
      logic [SEC_WIDTH-1:0]  seconds;
      logic [MIN_WIDTH-1:0]  minutes;
      logic [HOUR_WIDTH-1:0] hours;
   } hms_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   localparam logic [3:0] BIG_FONT [10][8] = '{
      '{4'h0, 4'hf, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'hf},
      '{4'h0, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4},
      '{4'h0, 4'hf, 4'h1, 4'h1, 4'hf, 4'h8, 4'h8, 4'hf},
      '{4'h0, 4'hf, 4'h1, 4'h1, 4'hf, 4'h1, 4'h1, 4'hf},
      '{4'h0, 4'h9, 4'h9, 4'h9, 4'hf, 4'h1, 4'h1, 4'h1},
      '{4'h0, 4'hf, 4'h8, 4'h8, 4'hf, 4'h1, 4'h1, 4'hf},
      '{4'h0, 4'hf, 4'h8, 4'h8, 4'hf, 4'h9, 4'h9, 4'hf},
      '{4'h0, 4'hf, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1},
      '{4'h0, 4'hf, 4'h9, 4'h9, 4'hf, 4'h9, 4'h9, 4'hf},
      '{4'h0, 4'hf, 4'h9, 4'h9, 4'hf, 4'h1, 4'h1, 4'hf}
   };

   localparam logic [2:0] SMALL_FONT [10][5] = '{
      '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
      '{3'h2, 3'h2, 3'h2, 3'h2, 3'h2},
      '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
      '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
      '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1},
      '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
      '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7},
      '{3'h7, 3'h1, 3'h1, 3'h1, 3'h1},
      '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
      '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7}
   };

   // tens by threshold count; a 6-bit value never exceeds six tens
   function automatic digits_type split_digits(input logic [5:0] value);
      digits_type result;
      logic [3:0] tens;
      logic [5:0] rem;
      tens = 4'd0;
      for (int i = 1; i <= 6; i++) begin
         if (value >= 6'(10 * i)) begin
            tens = tens + 4'd1;
         end
      end
      rem = value - (6'(tens) * 6'd10);
      result.tens  = tens;
      result.units = rem[3:0];
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: sv/cdr_time_keeper.sv
// Seconds, minutes and hours counters with 24-hour wrap
`default_nettype none

module cdr_time_keeper import cdr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    tick_en,
   output hms_type      hms
);

   hms_type hms_ff;
   hms_type hms_in;

   always_comb begin
      hms_in = hms_ff;
      if (tick_en) begin
         if (hms_ff.seconds >= SEC_LAST) begin
            hms_in.seconds = '0;
            if (hms_ff.minutes >= MIN_LAST) begin
               hms_in.minutes = '0;
               if (hms_ff.hours >= HOUR_LAST) begin
                  hms_in.hours = '0;
               end else begin
                  hms_in.hours = hms_ff.hours + HOUR_WIDTH'(1);
               end
            end else begin
               hms_in.minutes = hms_ff.minutes + MIN_WIDTH'(1);
            end
         end else begin
            hms_in.seconds = hms_ff.seconds + SEC_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hms_ff <= '0;
      end else begin
         hms_ff <= hms_in;
      end
   end

   assign hms = hms_ff;

endmodule

`default_nettype wire

FILE: sv/cdr_row_render.sv
// Font lookup and row assembly for one display row
`default_nettype none

module cdr_row_render import cdr_pkg::*; #(
   parameter int unsigned ROW_COUNT = 16
) (
   input  wire hms_type      hms,
   input  wire logic [3:0]   row_index,
   output logic      [31:0]  row_bits
);

   digits_type hour_d;
   digits_type min_d;
   digits_type sec_d;
   logic [3:0] ht, hu, mt, mu, st, su;
   logic [2:0] glyph_row;
   logic [2:0] small_row;
   logic       show_seconds;
   logic       show_colon;

   function automatic logic [3:0] clamp9(input logic [3:0] d);
      return (d > 4'd9) ? 4'd9 : d;
   endfunction

   always_comb begin
      hour_d = split_digits({1'b0, hms.hours});
      min_d  = split_digits(hms.minutes);
      sec_d  = split_digits(hms.seconds);
      ht = clamp9(hour_d.tens);
      hu = clamp9(hour_d.units);
      mt = clamp9(min_d.tens);
      mu = clamp9(min_d.units);
      st = clamp9(sec_d.tens);
      su = clamp9(sec_d.units);

      glyph_row    = row_index[2:0];
      show_seconds = (row_index >= FIRST_SECONDS_ROW) && (row_index <= LAST_GLYPH_ROW);
      small_row    = show_seconds ? (glyph_row - FIRST_SECONDS_ROW[2:0]) : 3'd0;
      show_colon   = row_index inside {4'd2, 4'd3, 4'd5, 4'd6};

      row_bits = '0;
      if ((row_index <= LAST_GLYPH_ROW) && (32'(row_index) < ROW_COUNT)) begin
         row_bits = row_bits | (32'(BIG_FONT[ht][glyph_row]) << HOUR_TENS_POS);
         row_bits = row_bits | (32'(BIG_FONT[hu][glyph_row]) << HOUR_UNIT_POS);
         row_bits = row_bits | (32'(BIG_FONT[mt][glyph_row]) << MIN_TENS_POS);
         row_bits = row_bits | (32'(BIG_FONT[mu][glyph_row]) << MIN_UNIT_POS);
         if (show_seconds) begin
            row_bits = row_bits | (32'(SMALL_FONT[st][small_row]) << SEC_TENS_POS);
            row_bits = row_bits | 32'(SMALL_FONT[su][small_row]);
         end
         if (show_colon) begin
            row_bits[COLON_POS] = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/clock_digit_row_renderer.sv
// Top level: time of day kept as counters, rendered as 32-pixel LED rows
//
//  channel | direction | payload                      | transaction
//  req     | in        | req_opcode, req_row_index    | tick or row request
//  rsp     | out       | rsp_row_bits                 | one row per row request
//
//  One transaction per cycle unless a row request waits on a held response.
//  Ticks update the counters from the input register and give no response.
//  The response register holds under back-pressure; ticks still drain past it.
//  Synchronous reset clears the time to 00:00:00 and empties both registers.
`default_nettype none

module clock_digit_row_renderer import cdr_pkg::*; #(
   parameter int unsigned ROW_COUNT = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [3:0]  req_row_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_row_bits
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_opcode_ff;
   logic [3:0]  s1_row_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_row_bits_ff;
   logic        s1_advance;
   logic        tick_en;
   logic        rsp_load;
   hms_type     hms;
   logic [31:0] row_bits;

   assign s1_advance = s1_valid_ff &&
                       ((s1_opcode_ff == OP_TICK) || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign tick_en    = s1_advance && (s1_opcode_ff == OP_TICK);
   assign rsp_load   = s1_advance && (s1_opcode_ff == OP_ROW);

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   cdr_time_keeper u_time_keeper (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .hms     (hms)
   );

   cdr_row_render #(
      .ROW_COUNT (ROW_COUNT)
   ) u_row_render (
      .hms       (hms),
      .row_index (s1_row_ff),
      .row_bits  (row_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_opcode_ff <= req_opcode;
         s1_row_ff    <= req_row_index;
      end
      if (rsp_load) begin
         rsp_row_bits_ff <= row_bits;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_bits = rsp_row_bits_ff;

endmodule

`default_nettype wire

FILE: sv/cdr_checker.sv
// Port-level checks for the clock digit row renderer, bound to the top level
`default_nettype none
`include "clock_digit_row_renderer_assert.svh"

module cdr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_opcode,
   input wire logic [3:0]  req_row_index,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_row_bits
);

   logic rsp_stalled;
   logic req_seen;

   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign req_seen    = req_valid && req_ready && (req_opcode || (req_row_index != 4'd0));

   `CDR_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, $past(reset) |-> !rsp_valid, "rsp_valid after reset")
   `CDR_ASSERT_IMPLY(a_rsp_hold, clock, reset, $past(rsp_stalled), rsp_valid && $stable(rsp_row_bits), "stalled response changed")
   `CDR_ASSERT_IMPLY(a_dark_columns, clock, reset, rsp_valid, (rsp_row_bits[31] == 1'b0) && (rsp_row_bits[18:17] == 2'b00) && (rsp_row_bits[7] == 1'b0) && (rsp_row_bits[3] == 1'b0), "unused column lit")
   `CDR_ASSERT_IMPLY(a_colon_with_glyphs, clock, reset, rsp_valid && rsp_row_bits[19], (rsp_row_bits[30:27] != 4'd0) && (rsp_row_bits[11:8] != 4'd0), "colon without digits")
   `CDR_ASSERT_IMPLY(a_seconds_with_glyphs, clock, reset, rsp_valid && (rsp_row_bits[6:0] != 7'd0) && !req_seen, rsp_row_bits[11:8] != 4'd0, "seconds without digits")

endmodule

bind clock_digit_row_renderer cdr_checker u_cdr_checker (.*);

`default_nettype wire

FILE: bench/clock_digit_row_renderer_test.sv
// Self-checking bench for the clock digit row renderer: queued stimulus, row prediction, scoreboard
`timescale 1ns / 1ps

module clock_digit_row_renderer_test import cdr_pkg::*;;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RANDOM_ITEMS = 340;

   typedef struct {
      logic        opcode;
      logic [3:0]  row_index;
      int unsigned send_idle;
      int unsigned recv_stall;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_opcode = OP_TICK;
   logic [3:0]  req_row_index = 4'd0;
   logic        rsp_ready = 1'b0;
   wire logic   req_ready;
   wire logic   rsp_valid;
   wire logic [31:0] rsp_row_bits;

   req_item_type pending_reqs[$];
   logic [31:0] row_bits_due[$];
   hms_type     clock_time = '0;
   hms_type     plan_time = '0;
   int unsigned plan_send_idle = 0;
   int unsigned plan_recv_stall = 0;
   int unsigned stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;

   clock_digit_row_renderer i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_row_index (req_row_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_bits  (rsp_row_bits)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // glyph rows packed top row first, one nibble per row; anything above 9 shows as 9
   function automatic logic [31:0] big_digit_rows(input int unsigned d);
      case (d)
         0: return 32'h0F99999F;
         1: return 32'h04444444;
         2: return 32'h0F11F88F;
         3: return 32'h0F11F11F;
         4: return 32'h0999F111;
         5: return 32'h0F88F11F;
         6: return 32'h0F88F99F;
         7: return 32'h0F111111;
         8: return 32'h0F99F99F;
         default: return 32'h0F99F11F;
      endcase
   endfunction

   function automatic logic [19:0] small_digit_rows(input int unsigned d);
      case (d)
         0: return 20'h75557;
         1: return 20'h22222;
         2: return 20'h71747;
         3: return 20'h71717;
         4: return 20'h55711;
         5: return 20'h74717;
         6: return 20'h74757;
         7: return 20'h71111;
         8: return 20'h75757;
         default: return 20'h75717;
      endcase
   endfunction

   function automatic hms_type advance_second(input hms_type t);
      hms_type n;
      n = t;
      if (t.seconds >= 6'd59) begin
         n.seconds = '0;
         if (t.minutes >= 6'd59) begin
            n.minutes = '0;
            if (t.hours >= 5'd23) begin
               n.hours = '0;
            end else begin
               n.hours = t.hours + 5'd1;
            end
         end else begin
            n.minutes = t.minutes + 6'd1;
         end
      end else begin
         n.seconds = t.seconds + 6'd1;
      end
      return n;
   endfunction

   function automatic logic [31:0] render_row(input hms_type t, input logic [3:0] row);
      logic [31:0] v;
      logic [31:0] big;
      logic [19:0] sml;
      int unsigned r;
      int unsigned k;
      v = '0;
      r = row;
      if (r <= 7) begin
         big = big_digit_rows(t.hours / 10);
         v[30:27] = big[31 - 4*r -: 4];
         big = big_digit_rows(t.hours % 10);
         v[25:22] = big[31 - 4*r -: 4];
         big = big_digit_rows(t.minutes / 10);
         v[16:13] = big[31 - 4*r -: 4];
         big = big_digit_rows(t.minutes % 10);
         v[11:8] = big[31 - 4*r -: 4];
         if (r >= 3) begin
            k = r - 3;
            sml = small_digit_rows(t.seconds / 10);
            v[6:4] = sml[18 - 4*k -: 3];
            sml = small_digit_rows(t.seconds % 10);
            v[2:0] = sml[18 - 4*k -: 3];
         end
         if (r == 2 || r == 3 || r == 5 || r == 6) begin
            v[19] = 1'b1;
         end
      end
      return v;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic queue_item(input logic op, input logic [3:0] row);
      req_item_type item;
      item.opcode     = op;
      item.row_index  = row;
      item.send_idle  = plan_send_idle;
      item.recv_stall = plan_recv_stall;
      pending_reqs.push_back(item);
      if (op == OP_TICK) begin
         plan_time = advance_second(plan_time);
      end
   endtask

   // ticks until the seconds count reads s, a stray row request now and then
   task automatic fast_forward(input int unsigned s);
      while (plan_time.seconds != 6'(s)) begin
         queue_item(OP_TICK, 4'($urandom));
         if ($urandom_range(0, 299) == 0) begin
            queue_item(OP_ROW, 4'($urandom_range(0, 15)));
         end
      end
   endtask

   // mostly short tick bursts followed by a row scan, the rest random transactions
   task automatic queue_random(input int unsigned count);
      int unsigned n;
      int unsigned ticks;
      int unsigned first;
      int unsigned last;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) < 7) begin
            ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 120) : $urandom_range(0, 3);
            repeat (ticks) queue_item(OP_TICK, 4'($urandom));
            first = $urandom_range(0, 2);
            last  = ($urandom_range(0, 3) == 0) ? 15 : 7;
            for (int unsigned k = first; k <= last; k++) begin
               queue_item(OP_ROW, 4'(k));
            end
            n += ticks + last - first + 1;
         end else begin
            queue_item(1'($urandom), 4'($urandom));
            n++;
         end
      end
   endtask

   always @(posedge clock) begin : drive_req
      req_item_type next_item;
      logic      take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_opcode == OP_ROW) begin
               row_bits_due.push_back(render_row(clock_time, req_row_index));
            end else begin
               clock_time = advance_second(clock_time);
            end
         end
         if (!req_valid || req_ready) begin
            take = 1'b0;
            if (pending_reqs.size() != 0) begin
               if ($urandom_range(0, 99) >= pending_reqs[0].send_idle) begin
                  next_item = pending_reqs.pop_front();
                  take = 1'b1;
               end
            end
            if (take) begin
               req_valid     <= 1'b1;
               req_opcode    <= next_item.opcode;
               req_row_index <= next_item.row_index;
               stall_pct     <= next_item.recv_stall;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      logic [31:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (row_bits_due.size() == 0) begin
               flag_mismatch($sformatf("row 0x%08h with no request waiting", rsp_row_bits));
            end else begin
               want = row_bits_due.pop_front();
               if (rsp_row_bits !== want) begin
                  flag_mismatch($sformatf("row_bits 0x%08h, want 0x%08h", rsp_row_bits, want));
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          !(pending_reqs.size() != 0 || req_valid || row_bits_due.size() != 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("clock_digit_row_renderer verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_test
      // directed: both row extremes, blank rows, a tick, the minute carry
      for (int unsigned k = 0; k < 16; k++) begin
         queue_item(OP_ROW, 4'(k));
      end
      queue_item(OP_TICK, 4'hF);
      queue_item(OP_ROW, 4'd3);
      fast_forward(59);
      for (int unsigned k = 2; k < 8; k++) begin
         queue_item(OP_ROW, 4'(k));
      end
      queue_item(OP_TICK, 4'h0);
      queue_item(OP_ROW, 4'd3);
      queue_item(OP_ROW, 4'd5);
      queue_random(RANDOM_ITEMS);

      plan_send_idle  = 58;
      plan_recv_stall = 0;
      fast_forward(57);
      queue_random(RANDOM_ITEMS);

      plan_send_idle  = 0;
      plan_recv_stall = 58;
      fast_forward(57);
      queue_random(RANDOM_ITEMS);

      plan_send_idle  = 14;
      plan_recv_stall = 14;
      fast_forward(50);
      queue_random(RANDOM_ITEMS);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || row_bits_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (row_bits_due.size() != 0) begin
         flag_mismatch($sformatf("%0d rows never returned", row_bits_due.size()));
      end
      if (mismatch_count == 0) begin
         $display("clock_digit_row_renderer verification clean");
      end else begin
         $display("clock_digit_row_renderer verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/cdr_pkg.sv
sv/cdr_time_keeper.sv
sv/cdr_row_render.sv
sv/clock_digit_row_renderer.sv
sv/cdr_checker.sv
bench/clock_digit_row_renderer_test.sv
